>>> hdl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token codes, character classes and symbol and keyword tables
// for the source token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  // Default widths of the running byte offset and of the open token length.
  localparam int OFFSET_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF = 12;

  // Fixed widths of the result fields.
  localparam int KIND_W   = 6;
  localparam int OFFSET_W = 16;
  localparam int LENGTH_W = 12;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_IDENT_KW0 = 6'd0;
  localparam logic [KIND_W-1:0] K_SYM0      = 6'd8;
  localparam logic [KIND_W-1:0] K_INT       = 6'd55;
  localparam logic [KIND_W-1:0] K_HEX       = 6'd56;
  localparam logic [KIND_W-1:0] K_BIN       = 6'd57;
  localparam logic [KIND_W-1:0] K_FLOAT     = 6'd58;
  localparam logic [KIND_W-1:0] K_STRING    = 6'd59;
  localparam logic [KIND_W-1:0] K_IDENT     = 6'd60;
  localparam logic [KIND_W-1:0] K_MACRO     = 6'd61;
  localparam logic [KIND_W-1:0] K_ILLEGAL   = 6'd62;
  localparam logic [KIND_W-1:0] K_END       = 6'd63;

  // Character codes with a special meaning.
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Lexer mode.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_IDENT = 3'd2,
    MODE_STR   = 3'd3,
    MODE_SYM   = 3'd4
  } stl_mode_t;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic                last;
  } stl_res_t;

  // Results produced by one input item, handed to the result queue.
  typedef struct packed {
    logic [1:0] cnt;
    stl_res_t   r0;
    stl_res_t   r1;
  } stl_push_t;

  // Outcome of a symbol table lookup.
  typedef struct packed {
    logic                hit;
    logic [KIND_W-1:0]   idx;
    logic                grows;
  } stl_sym_t;

  localparam int NSYM = 47;
  localparam int NKW  = 8;

  // Symbol text, first byte in the low bits, and symbol lengths.
  localparam logic [23:0] SYM_TEXT [NSYM] = '{
    24'h00002E, 24'h00002C, 24'h00003B, 24'h00003A, 24'h003A3A, 24'h003E2D,
    24'h00003F, 24'h00002B, 24'h00002D, 24'h00002A, 24'h00002F, 24'h002A2A,
    24'h000025, 24'h000026, 24'h00007E, 24'h003C3C, 24'h003E3E, 24'h00005E,
    24'h00007C, 24'h000021, 24'h002B2B, 24'h002D2D, 24'h002626, 24'h007C7C,
    24'h00003C, 24'h00003E, 24'h002E2E, 24'h000028, 24'h000029, 24'h00005B,
    24'h00005D, 24'h00007B, 24'h00007D, 24'h00003D, 24'h003D3D, 24'h003D2B,
    24'h003D2A, 24'h003D2F, 24'h3D2A2A, 24'h003D25, 24'h003D26, 24'h003D5E,
    24'h003D7C, 24'h003D21, 24'h003D3C, 24'h003D3E, 24'h3D2E2E
  };
  localparam logic [1:0] SYM_LEN [NSYM] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2,
    2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3
  };

  // Keywords, first byte in the low bits, padded with zero bytes.
  localparam logic [39:0] KW_TEXT [NKW] = '{
    40'h0000726176, 40'h6F7263616D, 40'h00636E7566, 40'h0065707974,
    40'h656C696877, 40'h0000726F66, 40'h0000006669, 40'h0065736C65
  };
  localparam logic [2:0] KW_LEN [NKW] = '{
    3'd3, 3'd5, 3'd4, 3'd4, 3'd5, 3'd3, 3'd2, 3'd4
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Looks up the first len bytes of b; also tells whether a symbol one byte
  // longer starts with them.
  function automatic stl_sym_t sym_lookup(input logic [23:0] b, input logic [1:0] len);
    stl_sym_t   r;
    logic [23:0] m;
    logic [2:0]  len_up;
    r = '0;
    len_up = {1'b0, len} + 3'd1;
    case (len)
      2'd1:    m = 24'h0000FF;
      2'd2:    m = 24'h00FFFF;
      2'd3:    m = 24'hFFFFFF;
      default: m = 24'h000000;
    endcase
    for (int i = 0; i < NSYM; i++) begin
      if ((SYM_TEXT[i] & m) == (b & m)) begin
        if (SYM_LEN[i] == len && !r.hit) begin
          r.hit = 1'b1;
          r.idx = K_SYM0 + KIND_W'(i);
        end
        if ({1'b0, SYM_LEN[i]} == len_up) begin
          r.grows = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/stl_in_if.sv
// ----------------------------------------------------------------------------
// stl_in_if
// Source byte channel: one text byte or end-of-text mark per item.
// ----------------------------------------------------------------------------
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> hdl/stl_out_if.sv
// ----------------------------------------------------------------------------
// stl_out_if
// Token channel: one token per item.
// ----------------------------------------------------------------------------
interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] token_offset;
  logic [11:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_offset,
                  input token_length, input last_of_run, output ready);
endinterface

>>> hdl/stl_core.sv
// ----------------------------------------------------------------------------
// stl_core
// Lexer state registers and the per-byte decision logic. Each accepted item
// updates the state and yields zero, one or two tokens.
// ----------------------------------------------------------------------------
module stl_core #(
  parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = stl_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output stl_pkg::stl_push_t push
);

  // State registers.
  stl_pkg::stl_mode_t        mode_r, mode_nxt;
  logic [5:0]                kind_r, kind_nxt;
  logic [OFFSET_BITS-1:0]    start_r, start_nxt;
  logic [LENGTH_BITS-1:0]    len_r, len_nxt;
  logic [OFFSET_BITS-1:0]    pos_r, pos_nxt;
  logic [39:0]               prefix_r, prefix_nxt;
  logic [7:0]                quote_r, quote_nxt;
  logic [15:0]               pend_r, pend_nxt;
  logic                      lz_r, lz_nxt;

  // Shared decode.
  logic                      is_end;
  logic [LENGTH_BITS-1:0]    glen;
  logic [OFFSET_BITS-1:0]    pos_inc;
  logic [5:0]                word_kind;
  logic [31:0]               len_w;
  logic                      num_take;
  logic [5:0]                num_kind;
  logic [1:0]                sym_len;
  logic [23:0]               sym_bytes;
  stl_pkg::stl_sym_t         sym_close, sym_next, sym_one;
  logic                      sym_cont;
  logic                      macro_hit;
  logic                      go_begin;
  logic                      do_close;
  logic [5:0]                close_kind;

  function automatic logic [15:0] to_off(input logic [OFFSET_BITS-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return w[15:0];
  endfunction

  function automatic logic [11:0] to_len(input logic [LENGTH_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[11:0];
  endfunction

  function automatic stl_pkg::stl_res_t mk(input logic [5:0] k, input logic [15:0] o,
                                           input logic [11:0] l);
    stl_pkg::stl_res_t r;
    r.kind   = k;
    r.offset = o;
    r.length = l;
    r.last   = 1'b0;
    return r;
  endfunction

  // Classification of the current byte against the open token.
  always_comb begin
    is_end  = end_of_text || (text_byte == stl_pkg::CH_NUL);
    glen    = (len_r != '1) ? len_r + 1'b1 : len_r;
    pos_inc = (pos_r != '1) ? pos_r + 1'b1 : pos_r;
    len_w   = 32'(len_r);

    word_kind = stl_pkg::K_IDENT;
    for (int i = stl_pkg::NKW - 1; i >= 0; i--) begin
      if (len_w == 32'(stl_pkg::KW_LEN[i]) && prefix_r == stl_pkg::KW_TEXT[i]) begin
        word_kind = stl_pkg::K_IDENT_KW0 + 6'(i);
      end
    end

    num_take = 1'b0;
    num_kind = kind_r;
    if (kind_r == stl_pkg::K_INT) begin
      if (lz_r && len_w == 32'd1 &&
          (text_byte == stl_pkg::CH_X || text_byte == stl_pkg::CH_B)) begin
        num_take = 1'b1;
        num_kind = (text_byte == stl_pkg::CH_X) ? stl_pkg::K_HEX : stl_pkg::K_BIN;
      end else if (stl_pkg::is_digit(text_byte)) begin
        num_take = 1'b1;
      end else if (text_byte == stl_pkg::CH_DOT) begin
        num_take = 1'b1;
        num_kind = stl_pkg::K_FLOAT;
      end
    end else if (kind_r == stl_pkg::K_FLOAT) begin
      num_take = stl_pkg::is_digit(text_byte);
    end else if (kind_r == stl_pkg::K_HEX) begin
      num_take = stl_pkg::is_xdigit(text_byte);
    end else begin
      num_take = (text_byte == stl_pkg::CH_ZERO) || (text_byte == stl_pkg::CH_ONE);
    end

    sym_len   = len_r[1:0];
    sym_close = stl_pkg::sym_lookup({8'h00, pend_r}, sym_len);
    case (sym_len)
      2'd1:    sym_bytes = {8'h00, text_byte, pend_r[7:0]};
      2'd2:    sym_bytes = {text_byte, pend_r};
      default: sym_bytes = {8'h00, pend_r};
    endcase
    sym_next  = stl_pkg::sym_lookup(sym_bytes, sym_len + 2'd1);
    sym_one   = stl_pkg::sym_lookup({16'h0000, text_byte}, 2'd1);
    sym_cont  = (mode_r == stl_pkg::MODE_SYM) && (sym_len != 2'd3) && sym_next.hit;

    macro_hit = (mode_r == stl_pkg::MODE_IDENT) && !stl_pkg::is_word(text_byte) &&
                (text_byte == stl_pkg::CH_BANG) && (word_kind == stl_pkg::K_IDENT);

    go_begin = 1'b0;
    if (!is_end) begin
      case (mode_r)
        stl_pkg::MODE_IDLE:  go_begin = 1'b1;
        stl_pkg::MODE_NUM:   go_begin = !num_take;
        stl_pkg::MODE_IDENT: go_begin = !stl_pkg::is_word(text_byte) && !macro_hit;
        stl_pkg::MODE_SYM:   go_begin = !sym_cont;
        default:             go_begin = 1'b0;
      endcase
    end
    do_close = (mode_r != stl_pkg::MODE_IDLE) && (is_end || go_begin);

    case (mode_r)
      stl_pkg::MODE_IDENT: close_kind = word_kind;
      stl_pkg::MODE_STR:   close_kind = stl_pkg::K_ILLEGAL;
      stl_pkg::MODE_SYM:   close_kind = sym_close.hit ? sym_close.idx : stl_pkg::K_ILLEGAL;
      default:             close_kind = kind_r;
    endcase
  end

  // Next state.
  always_comb begin
    mode_nxt   = mode_r;
    kind_nxt   = kind_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    prefix_nxt = prefix_r;
    quote_nxt  = quote_r;
    pend_nxt   = pend_r;
    lz_nxt     = lz_r;
    if (is_end) begin
      mode_nxt   = stl_pkg::MODE_IDLE;
      kind_nxt   = '0;
      start_nxt  = '0;
      len_nxt    = '0;
      pos_nxt    = '0;
      prefix_nxt = '0;
      quote_nxt  = '0;
      pend_nxt   = '0;
      lz_nxt     = 1'b0;
    end else begin
      pos_nxt = pos_inc;
      case (mode_r)
        stl_pkg::MODE_NUM: begin
          lz_nxt = 1'b0;
          if (num_take) begin
            kind_nxt = num_kind;
            len_nxt  = glen;
          end
        end
        stl_pkg::MODE_IDENT: begin
          if (stl_pkg::is_word(text_byte)) begin
            if (len_w < 32'd5) begin
              prefix_nxt = prefix_r | (40'(text_byte) << (8 * len_w[2:0]));
            end
            len_nxt = glen;
          end else if (macro_hit) begin
            len_nxt  = glen;
            mode_nxt = stl_pkg::MODE_IDLE;
          end
        end
        stl_pkg::MODE_STR: begin
          len_nxt = glen;
          if (text_byte == quote_r) begin
            mode_nxt = stl_pkg::MODE_IDLE;
          end
        end
        stl_pkg::MODE_SYM: begin
          if (sym_cont) begin
            len_nxt = LENGTH_BITS'(sym_len + 2'd1);
            if (sym_len == 2'd1) begin
              pend_nxt = {text_byte, pend_r[7:0]};
            end
            if (!sym_next.grows) begin
              mode_nxt = stl_pkg::MODE_IDLE;
            end
          end
        end
        default: ;
      endcase
      if (go_begin) begin
        mode_nxt  = stl_pkg::MODE_IDLE;
        start_nxt = pos_r;
        len_nxt   = LENGTH_BITS'(1);
        if (stl_pkg::is_space(text_byte)) begin
          mode_nxt = stl_pkg::MODE_IDLE;
        end else if (stl_pkg::is_digit(text_byte)) begin
          mode_nxt = stl_pkg::MODE_NUM;
          kind_nxt = stl_pkg::K_INT;
          lz_nxt   = (text_byte == stl_pkg::CH_ZERO);
        end else if (stl_pkg::is_alpha(text_byte) || text_byte == stl_pkg::CH_UNDER) begin
          mode_nxt   = stl_pkg::MODE_IDENT;
          kind_nxt   = stl_pkg::K_IDENT;
          prefix_nxt = 40'(text_byte);
        end else if (text_byte == stl_pkg::CH_DQUOTE || text_byte == stl_pkg::CH_SQUOTE) begin
          mode_nxt  = stl_pkg::MODE_STR;
          kind_nxt  = stl_pkg::K_STRING;
          quote_nxt = text_byte;
        end else if (sym_one.hit && sym_one.grows) begin
          mode_nxt = stl_pkg::MODE_SYM;
          pend_nxt = {8'h00, text_byte};
        end
      end
    end
  end

  // Result tokens for this item.
  always_comb begin
    stl_pkg::stl_res_t ra, rb;
    logic ea, eb;
    ea = do_close;
    ra = mk(close_kind, to_off(start_r), to_len(len_r));
    eb = 1'b0;
    rb = mk(stl_pkg::K_END, to_off(pos_r), 12'd0);
    if (is_end) begin
      eb = 1'b1;
    end else if (macro_hit) begin
      eb = 1'b1;
      rb = mk(stl_pkg::K_MACRO, to_off(start_r), to_len(glen));
    end else if (mode_r == stl_pkg::MODE_STR && text_byte == quote_r) begin
      eb = 1'b1;
      rb = mk(stl_pkg::K_STRING, to_off(start_r), to_len(glen));
    end else if (sym_cont && !sym_next.grows) begin
      eb = 1'b1;
      rb = mk(sym_next.idx, to_off(start_r), 12'(sym_len) + 12'd1);
    end else if (go_begin && !stl_pkg::is_space(text_byte) &&
                 !stl_pkg::is_word(text_byte) && text_byte != stl_pkg::CH_DQUOTE &&
                 text_byte != stl_pkg::CH_SQUOTE) begin
      if (!sym_one.hit) begin
        eb = 1'b1;
        rb = mk(stl_pkg::K_ILLEGAL, to_off(pos_r), 12'd1);
      end else if (!sym_one.grows) begin
        eb = 1'b1;
        rb = mk(sym_one.idx, to_off(pos_r), 12'd1);
      end
    end
    push.r0 = '0;
    push.r1 = '0;
    push.cnt = '0;
    if (acc) begin
      push.cnt = {1'b0, ea} + {1'b0, eb};
      if (ea) begin
        push.r0 = ra;
        push.r1 = rb;
      end else begin
        push.r0 = rb;
      end
      if (ea && eb) begin
        push.r1.last = 1'b1;
      end else begin
        push.r0.last = 1'b1;
      end
    end
  end

  // State update on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= stl_pkg::MODE_IDLE;
      kind_r   <= '0;
      start_r  <= '0;
      len_r    <= '0;
      pos_r    <= '0;
      prefix_r <= '0;
      quote_r  <= '0;
      pend_r   <= '0;
      lz_r     <= 1'b0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      kind_r   <= kind_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      prefix_r <= prefix_nxt;
      quote_r  <= quote_nxt;
      pend_r   <= pend_nxt;
      lz_r     <= lz_nxt;
    end
  end

endmodule

>>> hdl/stl_res_fifo.sv
// ----------------------------------------------------------------------------
// stl_res_fifo
// Four-entry token queue: up to two tokens in per cycle, one out on ready.
// ----------------------------------------------------------------------------
module stl_res_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  stl_pkg::stl_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output stl_pkg::stl_res_t  out_res
);

  stl_pkg::stl_res_t mem [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  // Queue control.
  always_comb begin
    pop       = out_valid && out_ready;
    wr_nxt    = wr_r + push.cnt;
    rd_nxt    = rd_r + {1'b0, pop};
    cnt_nxt   = cnt_r + {1'b0, push.cnt} - {2'b00, pop};
    room      = (cnt_r <= 3'd2);
    out_valid = (cnt_r != 3'd0);
    out_res   = mem[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_r + 2'd1] <= push.r1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> (cnt_r <= 3'd2))
    else $error("token queue written without room");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("token queue count out of range");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.cnt == 2'd0) |=> (cnt_r == $past(cnt_r) - 3'd1))
    else $error("token queue count lost a pop");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 3'd4) |-> (wr_r - rd_r == cnt_r[1:0]))
    else $error("token queue pointers disagree with count");
`endif

endmodule

>>> hdl/source_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// source_token_lexer_unit
// Streaming maximal-munch lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per cycle while in_ready is high and
// decides its effect in the same cycle; a byte yields no token, one token,
// or two tokens (the token it closes and one it completes). Tokens leave
// through a four-entry queue at one per cycle, so in_ready drops only while
// more than two tokens are waiting; the output port sets the sustained rate,
// and bytes that close two tokens cost an extra output slot. Tokens are
// queued in registers before output. End of text, or a zero byte, flushes
// the open token, emits the end token and restarts offsets at zero.
module source_token_lexer_unit #(
  parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = stl_pkg::LENGTH_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  stl_in_if.sink    in_ch,
  stl_out_if.source out_ch
);

  stl_pkg::stl_push_t push;
  stl_pkg::stl_res_t  res;
  logic               room;
  logic               acc;

  assign in_ch.ready = room;
  assign acc         = in_ch.valid && room;

  // Per-byte decision and lexer state.
  stl_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .text_byte   (in_ch.text_byte),
    .end_of_text (in_ch.end_of_text),
    .push        (push)
  );

  // Token queue toward the output.
  stl_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.token_kind   = res.kind;
  assign out_ch.token_offset = res.offset;
  assign out_ch.token_length = res.length;
  assign out_ch.last_of_run  = res.last;

endmodule
